// ===== hdl/keyboard_target_selector_macros.svh =====
// assertion macros used by the keyboard target selector top level
`ifndef KEYBOARD_TARGET_SELECTOR_MACROS_SVH
`define KEYBOARD_TARGET_SELECTOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define KTS_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("keyboard target selector check failed");

// next-cycle implication, checked out of reset
`define KTS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("keyboard target selector check failed");

`endif

// ===== hdl/kts_pkg.sv =====
// types, constants and helper functions of the keyboard target selector
package kts_pkg;

  localparam int unsigned NumHosts = 3;
  localparam int unsigned HostW    = 2;

  typedef logic [HostW-1:0]    host_t;
  typedef logic [NumHosts-1:0] hmask_t;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_LOOP   = 2'd1,
    CMD_REPORT = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    REG_SAMPLE_TICKS = 2'd0,
    REG_COMBO_CODE   = 2'd1,
    REG_NEXT_CODE    = 2'd2,
    REG_PREV_CODE    = 2'd3
  } cfg_reg_e;

  localparam logic [7:0] SampleTicksRst = 8'd3;
  localparam logic [7:0] ComboCodeRst   = 8'h22;
  localparam logic [7:0] NextCodeRst    = 8'h02;
  localparam logic [7:0] PrevCodeRst    = 8'h20;
  localparam hmask_t     PilotRst       = 3'b110;
  localparam logic [6:0] HotkeyEp       = 7'd1;

  typedef struct packed {
    logic [7:0] sample_ticks;
    logic [7:0] combo_code;
    logic [7:0] next_code;
    logic [7:0] prev_code;
  } cfg_t;

  typedef struct packed {
    logic [7:0]                 tick_count;
    logic                       sampled_button;
    logic                       previous_button;
    host_t                      selection;
    hmask_t                     active_hosts;
    logic [7:0]                 previous_modifier;
    logic [NumHosts-1:0][7:0]   host_led_memory;
    hmask_t                     pilot_drive;
  } state_t;

  typedef struct packed {
    cmd_e       cmd;
    logic       raw_button;
    hmask_t     host_active;
    logic [6:0] report_endpoint;
    logic [7:0] report_first_byte;
    logic [7:0] host_led_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] led_value;
    logic       led_write;
    hmask_t     pilot_pattern;
    host_t      forward_host;
    host_t      selected_host;
  } result_t;

  function automatic host_t next_host(host_t h);
    host_t r;
    case (h)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic host_on(hmask_t act, host_t h);
    logic r;
    case (h)
      2'd0:    r = act[0];
      2'd1:    r = act[1];
      2'd2:    r = act[2];
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // one-cold drive, low bit lights the led
  function automatic hmask_t pilot_for(host_t h);
    hmask_t r;
    case (h)
      2'd0:    r = 3'b110;
      2'd1:    r = 3'b101;
      default: r = 3'b011;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/kts_step.sv =====
// next-state and result logic for one word of the keyboard target selector
module kts_step import kts_pkg::*; (
  input  state_t  st_q_i,
  input  cfg_t    cfg_i,
  input  item_t   item_i,
  output state_t  st_d_o,
  output result_t res_o
);

  logic [7:0] tick_inc;
  logic [7:0] cur_led;
  host_t      sel_btn;
  host_t      sel_skip1;
  host_t      sel_skip2;
  logic       move_up;
  logic       move_dn;

  assign tick_inc = st_q_i.tick_count + 8'd1;

  always_comb begin
    cur_led = st_q_i.host_led_memory[0];
    for (int i = 0; i < NumHosts; i++) begin
      if (st_q_i.selection == HostW'(i)) begin
        cur_led = st_q_i.host_led_memory[i];
      end
    end
  end

  // loop pass: button edge first, then skip inactive hosts up to twice
  always_comb begin
    sel_btn = st_q_i.selection;
    if (st_q_i.sampled_button != st_q_i.previous_button && !st_q_i.sampled_button) begin
      sel_btn = next_host(st_q_i.selection);
    end
    sel_skip1 = sel_btn;
    if (!host_on(item_i.host_active, sel_btn)) begin
      sel_skip1 = next_host(sel_btn);
    end
    sel_skip2 = sel_skip1;
    if (!host_on(item_i.host_active, sel_btn) && !host_on(item_i.host_active, sel_skip1)) begin
      sel_skip2 = next_host(sel_skip1);
    end
  end

  // hotkey direction, prev code takes priority
  always_comb begin
    move_up = 1'b0;
    move_dn = 1'b0;
    if (item_i.report_endpoint == HotkeyEp && item_i.report_first_byte == cfg_i.combo_code) begin
      if (st_q_i.previous_modifier == cfg_i.prev_code) begin
        move_dn = 1'b1;
      end else if (st_q_i.previous_modifier == cfg_i.next_code) begin
        move_up = 1'b1;
      end
    end
  end

  always_comb begin
    st_d_o              = st_q_i;
    res_o.forward_host  = st_q_i.selection;
    res_o.led_write     = 1'b0;
    res_o.led_value     = 8'd0;
    case (item_i.cmd)
      CMD_TICK: begin
        if (tick_inc == cfg_i.sample_ticks) begin
          st_d_o.sampled_button = item_i.raw_button;
          st_d_o.tick_count     = 8'd0;
        end else begin
          st_d_o.tick_count = tick_inc;
        end
      end
      CMD_LOOP: begin
        st_d_o.previous_button = st_q_i.sampled_button;
        st_d_o.active_hosts    = item_i.host_active;
        st_d_o.selection       = sel_skip2;
        if (host_on(item_i.host_active, sel_skip2)) begin
          st_d_o.pilot_drive = pilot_for(sel_skip2);
        end
      end
      CMD_REPORT: begin
        if (item_i.report_endpoint == HotkeyEp) begin
          st_d_o.previous_modifier = item_i.report_first_byte;
        end
        if (item_i.host_led_byte != cur_led) begin
          res_o.led_write = 1'b1;
          res_o.led_value = item_i.host_led_byte;
          for (int i = 0; i < NumHosts; i++) begin
            if (st_q_i.selection == HostW'(i)) begin
              st_d_o.host_led_memory[i] = item_i.host_led_byte;
            end
          end
        end
        if (move_up) begin
          case (st_q_i.selection)
            2'd0: begin
              if (st_q_i.active_hosts[1]) begin
                st_d_o.selection = 2'd1;
              end else if (st_q_i.active_hosts[2]) begin
                st_d_o.selection = 2'd2;
              end
            end
            2'd1: begin
              if (st_q_i.active_hosts[2]) begin
                st_d_o.selection = 2'd2;
              end
            end
            default: ;
          endcase
        end else if (move_dn) begin
          case (st_q_i.selection)
            2'd2: begin
              if (st_q_i.active_hosts[1]) begin
                st_d_o.selection = 2'd1;
              end else if (st_q_i.active_hosts[0]) begin
                st_d_o.selection = 2'd0;
              end
            end
            2'd1: begin
              if (st_q_i.active_hosts[0]) begin
                st_d_o.selection = 2'd0;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    res_o.selected_host = st_d_o.selection;
    res_o.pilot_pattern = st_d_o.pilot_drive;
  end

endmodule

// ===== hdl/keyboard_target_selector.sv =====
// top level of the keyboard target selector
// Picks which of three hosts gets the keyboard. Each input word (tick, loop
// pass or keyboard report, chosen by s_axis_tuser) updates the selector state
// and the result register at the edge that accepts it, so a word can be taken
// every cycle unless the output stalls. The result register holds one word;
// input is stalled only while that word waits and the output is not ready.
// m_axis_tvalid rises in the cycle after the accept. The user must write the
// config registers through cfg_we_i while no word is in flight; not enforced.
`include "keyboard_target_selector_macros.svh"

module keyboard_target_selector import kts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [7:0]  cfg_wdata_i,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // raw_button, host_active, report_endpoint,
                                      // report_first_byte, host_led_byte, zero pad
  input  logic [1:0]  s_axis_tuser,   // cmd
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // selected_host, forward_host, pilot_pattern,
                                      // led_write, led_value
);

  cfg_t    cfg_q;
  state_t  st_q;
  state_t  st_d;
  item_t   item;
  result_t res_d;
  result_t res_q;
  logic    m_valid_q;
  logic    in_acc;

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign item.cmd               = cmd_e'(s_axis_tuser);
  assign item.raw_button        = s_axis_tdata[0];
  assign item.host_active       = s_axis_tdata[3:1];
  assign item.report_endpoint   = s_axis_tdata[10:4];
  assign item.report_first_byte = s_axis_tdata[18:11];
  assign item.host_led_byte     = s_axis_tdata[26:19];

  kts_step u_step (
    .st_q_i (st_q),
    .cfg_i  (cfg_q),
    .item_i (item),
    .st_d_o (st_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_ticks <= SampleTicksRst;
      cfg_q.combo_code   <= ComboCodeRst;
      cfg_q.next_code    <= NextCodeRst;
      cfg_q.prev_code    <= PrevCodeRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_SAMPLE_TICKS: cfg_q.sample_ticks <= cfg_wdata_i;
        REG_COMBO_CODE:   cfg_q.combo_code   <= cfg_wdata_i;
        REG_NEXT_CODE:    cfg_q.next_code    <= cfg_wdata_i;
        REG_PREV_CODE:    cfg_q.prev_code    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.tick_count        <= 8'd0;
      st_q.sampled_button    <= 1'b1;
      st_q.previous_button   <= 1'b1;
      st_q.selection         <= '0;
      st_q.active_hosts      <= '0;
      st_q.previous_modifier <= 8'd0;
      st_q.host_led_memory   <= '0;
      st_q.pilot_drive       <= PilotRst;
    end else if (in_acc) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (in_acc) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = res_q;

  // selection never leaves the host range
  `KTS_ASSERT_NOW(a_sel_range, clk_i, rst_ni, 1'b1, st_q.selection != 2'd3)
  // pilot drive always lights exactly one led
  `KTS_ASSERT_NOW(a_pilot_one_cold, clk_i, rst_ni, 1'b1, $countones(st_q.pilot_drive) == 2)
  // only a loop pass may move the pilot leds
  `KTS_ASSERT_NEXT(a_pilot_loop_only, clk_i, rst_ni, in_acc && item.cmd != CMD_LOOP,
                   $stable(st_q.pilot_drive))
  // led value is zero unless a write is flagged
  `KTS_ASSERT_NOW(a_led_value_zero, clk_i, rst_ni, m_valid_q && !res_q.led_write,
                  res_q.led_value == 8'd0)

endmodule

// ===== tb/kts_checker.sv =====
`timescale 1ns / 1ps
// checker that predicts every result word of the keyboard target selector and compares it
module kts_checker import kts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // raw_button, host_active, report_endpoint,
                                      // report_first_byte, host_led_byte, zero pad
  input  logic [1:0]  s_axis_tuser,   // cmd
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // selected_host, forward_host, pilot_pattern,
                                      // led_write, led_value
  output int          fail_count_o,
  output int          pending_o
);

  // register copies, written as the block sees them
  logic [7:0] sample_ticks;
  logic [7:0] combo_code;
  logic [7:0] next_code;
  logic [7:0] prev_code;

  // selector state
  logic [7:0] tick_count;
  logic       button_level;
  logic       button_seen;
  host_t      sel;
  hmask_t     live_hosts;
  logic [7:0] last_modifier;
  logic [7:0] led_memory [NumHosts];
  hmask_t     pilot;

  result_t    owed_results [$];

  function automatic host_t rotate_up(host_t h);
    return (h == 2'd2) ? 2'd0 : h + 2'd1;
  endfunction

  task automatic step_selector(input logic [1:0] cmd, input logic [31:0] word,
                               output result_t res);
    logic       raw;
    hmask_t     act;
    logic [6:0] endpoint;
    logic [7:0] first_byte;
    logic [7:0] led_byte;
    int         dir;
    raw        = word[0];
    act        = word[3:1];
    endpoint   = word[10:4];
    first_byte = word[18:11];
    led_byte   = word[26:19];
    dir        = 0;
    res        = '0;
    res.forward_host = sel;
    case (cmd)
      CMD_TICK: begin
        tick_count = tick_count + 8'd1;
        if (tick_count == sample_ticks) begin
          button_level = raw;
          tick_count   = '0;
        end
      end
      CMD_LOOP: begin
        if (button_level != button_seen) begin
          if (!button_level) sel = rotate_up(sel);
          button_seen = button_level;
        end
        live_hosts = act;
        // skip inactive hosts, two steps at most
        if (!live_hosts[sel]) begin
          sel = rotate_up(sel);
          if (!live_hosts[sel]) sel = rotate_up(sel);
        end
        if (live_hosts[sel]) pilot = ~(3'b001 << sel);
      end
      CMD_REPORT: begin
        if (endpoint == HotkeyEp) begin
          if (first_byte == combo_code) begin
            if (last_modifier == prev_code) dir = -1;
            else if (last_modifier == next_code) dir = 1;
          end
          last_modifier = first_byte;
        end
        if (led_byte != led_memory[sel]) begin
          res.led_write  = 1'b1;
          res.led_value  = led_byte;
          led_memory[sel] = led_byte;
        end
        if (dir > 0) begin
          if (sel == 2'd0) begin
            if (live_hosts[1]) sel = 2'd1;
            else if (live_hosts[2]) sel = 2'd2;
          end else if (sel == 2'd1 && live_hosts[2]) begin
            sel = 2'd2;
          end
        end else if (dir < 0) begin
          if (sel == 2'd2) begin
            if (live_hosts[1]) sel = 2'd1;
            else if (live_hosts[0]) sel = 2'd0;
          end else if (sel == 2'd1 && live_hosts[0]) begin
            sel = 2'd0;
          end
        end
      end
      default: ;
    endcase
    res.selected_host = sel;
    res.pilot_pattern = pilot;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count_o = fail_count_o + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    result_t fresh;
    if (!rst_ni) begin
      sample_ticks  = SampleTicksRst;
      combo_code    = ComboCodeRst;
      next_code     = NextCodeRst;
      prev_code     = PrevCodeRst;
      tick_count    = '0;
      button_level  = 1'b1;
      button_seen   = 1'b1;
      sel           = '0;
      live_hosts    = '0;
      last_modifier = '0;
      for (int i = 0; i < NumHosts; i++) led_memory[i] = '0;
      pilot         = PilotRst;
      owed_results.delete();
      fail_count_o  = 0;
      pending_o     = 0;
    end else begin
      // a word leaving now belongs to an earlier input, so check before predicting
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (owed_results.size() == 0) begin
          $error("result word 0x%0h with nothing expected", m_axis_tdata);
          fail_count_o = fail_count_o + 1;
        end else begin
          want = owed_results.pop_front();
          check_field("selected_host", 8'(want.selected_host), 8'(got.selected_host));
          check_field("forward_host", 8'(want.forward_host), 8'(got.forward_host));
          check_field("pilot_pattern", 8'(want.pilot_pattern), 8'(got.pilot_pattern));
          check_field("led_write", 8'(want.led_write), 8'(got.led_write));
          check_field("led_value", want.led_value, got.led_value);
        end
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_SAMPLE_TICKS: sample_ticks = cfg_wdata_i;
          REG_COMBO_CODE:   combo_code   = cfg_wdata_i;
          REG_NEXT_CODE:    next_code    = cfg_wdata_i;
          REG_PREV_CODE:    prev_code    = cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        step_selector(s_axis_tuser, s_axis_tdata, fresh);
        owed_results.push_back(fresh);
      end
      pending_o = owed_results.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// top of the keyboard target selector testbench: clock, reset, stimulus and verdict
module testbench;
  import kts_pkg::*;

  localparam logic [1:0] CmdUnused  = 2'd3;
  localparam int         PhaseWords = 200;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [7:0]  cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  int          fail_count;
  int          pending;

  // settings as last written, so hotkey sequences can be built from them
  logic [7:0]  cur_period;
  logic [7:0]  cur_combo;
  logic [7:0]  cur_next;
  logic [7:0]  cur_prev;
  logic        steady;
  int          words_sent;

  always #6 clk = ~clk;

  keyboard_target_selector u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  kts_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  task automatic send_word(input logic [1:0] cmd, input logic raw, input hmask_t act,
                           input logic [6:0] ep, input logic [7:0] first,
                           input logic [7:0] led);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 20) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = cmd;
    s_axis_tdata  = {5'b0, led, first, ep, act, raw};
    do @(posedge clk); while (!s_axis_tready);
    if (cmd != CmdUnused) words_sent++;
  endtask

  task automatic program_settings(input logic [7:0] period, input logic [7:0] combo,
                                  input logic [7:0] nxt, input logic [7:0] prv);
    @(negedge clk);
    cfg_we = 1'b1;  cfg_addr = REG_SAMPLE_TICKS;  cfg_wdata = period;
    @(negedge clk);
    cfg_addr = REG_COMBO_CODE;  cfg_wdata = combo;
    @(negedge clk);
    cfg_addr = REG_NEXT_CODE;   cfg_wdata = nxt;
    @(negedge clk);
    cfg_addr = REG_PREV_CODE;   cfg_wdata = prv;
    @(negedge clk);
    cfg_we = 1'b0;
    cur_period = period;
    cur_combo  = combo;
    cur_next   = nxt;
    cur_prev   = prv;
  endtask

  task automatic drain;
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_modifier();
    case ($urandom_range(0, 3))
      0:       return cur_combo;
      1:       return cur_next;
      2:       return cur_prev;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // a small pool so the remembered led byte often matches
  function automatic logic [7:0] pick_led();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'h01;
      2:       return 8'h02;
      3:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic hmask_t pick_hosts();
    return ($urandom_range(0, 2) == 0) ? 3'b111 : 3'($urandom_range(0, 7));
  endfunction

  task automatic run_phase(input int budget);
    int   start_count;
    int   pick;
    int   n;
    logic lvl;
    start_count = words_sent;
    while (words_sent - start_count < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        // hold a button level for a random run of ticks, often long enough to be sampled, then a loop pass
        lvl = 1'($urandom_range(0, 1));
        if (cur_period == 8'd0 || cur_period > 8'd16)
          n = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(1, 8);
        else
          n = $urandom_range(1, 2 * cur_period + 1);
        repeat (n) send_word(CMD_TICK, lvl, 3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)),
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        send_word(CMD_LOOP, 1'($urandom_range(0, 1)), pick_hosts(),
                  7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), pick_led());
      end else if (pick < 45) begin
        // hotkey: direction code, then the combo byte
        send_word(CMD_REPORT, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), HotkeyEp,
                  ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) :
                  ($urandom_range(0, 1) ? cur_prev : cur_next), pick_led());
        send_word(CMD_REPORT, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), HotkeyEp,
                  ($urandom_range(0, 4) != 0) ? cur_combo : 8'($urandom_range(0, 255)),
                  pick_led());
      end else if (pick < 60) begin
        send_word(CMD_LOOP, 1'($urandom_range(0, 1)), pick_hosts(),
                  7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), pick_led());
      end else if (pick < 75) begin
        send_word(CMD_TICK, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                  7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), pick_led());
      end else if (pick < 98) begin
        send_word(CMD_REPORT, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                  ($urandom_range(0, 2) == 0) ? 7'($urandom_range(0, 127)) : HotkeyEp,
                  pick_modifier(), pick_led());
      end else begin
        send_word(CmdUnused, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                  7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_axis_tready = steady || ($urandom_range(0, 99) >= 20);
    end
  end

  initial begin
    #6_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    cfg_we        = 1'b0;
    cfg_addr      = REG_SAMPLE_TICKS;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_TICK;
    steady        = 1'b0;
    words_sent    = 0;
    cur_period    = SampleTicksRst;
    cur_combo     = ComboCodeRst;
    cur_next      = NextCodeRst;
    cur_prev      = PrevCodeRst;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // directed part on the reset settings
    send_word(CMD_LOOP, 1'b1, 3'b000, 7'd0, 8'h00, 8'h00);        // no host active
    send_word(CMD_LOOP, 1'b0, 3'b111, 7'd127, 8'hFF, 8'hFF);
    send_word(CMD_REPORT, 1'b0, 3'b000, HotkeyEp, PrevCodeRst, 8'hFF);
    send_word(CMD_REPORT, 1'b0, 3'b000, HotkeyEp, ComboCodeRst, 8'hFF);
    send_word(CMD_REPORT, 1'b1, 3'b111, HotkeyEp, PrevCodeRst, 8'h00);
    send_word(CMD_REPORT, 1'b1, 3'b111, HotkeyEp, ComboCodeRst, 8'h00);
    send_word(CMD_REPORT, 1'b0, 3'b000, HotkeyEp, ComboCodeRst, 8'hFF);
    send_word(CMD_REPORT, 1'b0, 3'b000, HotkeyEp, NextCodeRst, 8'h00);
    send_word(CMD_LOOP, 1'b0, 3'b101, 7'd0, 8'h00, 8'h00);
    send_word(CMD_REPORT, 1'b0, 3'b000, HotkeyEp, ComboCodeRst, 8'h00); // skips to host 2
    send_word(CMD_REPORT, 1'b0, 3'b000, HotkeyEp, PrevCodeRst, 8'h00);
    send_word(CMD_LOOP, 1'b0, 3'b100, 7'd0, 8'h00, 8'h00);
    send_word(CMD_REPORT, 1'b0, 3'b000, HotkeyEp, ComboCodeRst, 8'h00); // nothing lower
    send_word(CMD_REPORT, 1'b0, 3'b000, 7'd0, PrevCodeRst, 8'h55);
    send_word(CMD_REPORT, 1'b1, 3'b111, 7'd127, ComboCodeRst, 8'hAA);
    repeat (3) send_word(CMD_TICK, 1'b0, 3'b000, 7'd0, 8'h00, 8'h00);
    send_word(CMD_LOOP, 1'b1, 3'b111, 7'd0, 8'h00, 8'h00);        // press seen
    repeat (3) send_word(CMD_TICK, 1'b1, 3'b111, 7'd127, 8'hFF, 8'hFF);
    send_word(CMD_LOOP, 1'b0, 3'b010, 7'd0, 8'h00, 8'h00);
    send_word(CmdUnused, 1'b1, 3'b111, 7'd127, 8'hFF, 8'hFF);
    send_word(CMD_REPORT, 1'b1, 3'b111, HotkeyEp, 8'h00, 8'h00);
    drain;

    program_settings(8'd1, 8'h22, 8'h02, 8'h20);
    run_phase(PhaseWords);
    drain;
    program_settings(8'd255, 8'hFF, 8'h00, 8'h80);
    run_phase(PhaseWords);
    drain;
    // zero period samples only on the wrap; no idling through this stretch
    steady = 1'b1;
    program_settings(8'd0, 8'h00, 8'hFF, 8'hFF);
    run_phase(PhaseWords);
    drain;
    steady = 1'b0;
    program_settings(8'd2, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
    run_phase(PhaseWords);
    drain;
    program_settings(8'd7, 8'h5A, 8'h5A, 8'h5A);
    run_phase(PhaseWords);
    drain;
    program_settings(8'($urandom_range(1, 16)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_phase(PhaseWords);
    drain;
    repeat (4) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
